### hdl/lru_pr_pkg.sv
// Shared types and constants for the LRU page replacement block.
// No dependencies; every other file in hdl imports this package.
`default_nettype none

package lru_pr_pkg;

    // Fixed field widths of the channels
    localparam int PAGE_W      = 16;
    localparam int CFG_W       = 4;
    localparam int FRAME_IDX_W = 3;
    localparam int FAULT_W     = 32;

    // Defaults for the top-level parameters
    localparam int FRAMES_DEF    = 8;
    localparam int PAGE_BITS_DEF = 16;

    // frames_in_use after reset
    localparam logic [CFG_W-1:0] CFG_RESET = CFG_W'(8);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_MATCH,
        ST_COMMIT
    } lru_state_t;

    // Controller to datapath
    typedef struct packed {
        logic take;     // latch the incoming page word
        logic lookup;   // register hit / fill / victim decision
        logic commit;   // update frames and load the result register
    } lru_cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic out_free; // result register can take a word this cycle
    } lru_sts_t;

endpackage

`default_nettype wire

### hdl/lru_pr_channels.sv
// Valid/ready channel interfaces: page input, result output and configuration.
// Depends on lru_pr_pkg for the field widths.
`default_nettype none

interface lru_pr_page_if import lru_pr_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [PAGE_W-1:0] page_number;

    modport source (output valid, output page_number, input ready);
    modport sink   (input valid, input page_number, output ready);
endinterface

interface lru_pr_result_if import lru_pr_pkg::*; ();
    logic                   valid;
    logic                   ready;
    logic                   hit;
    logic [FRAME_IDX_W-1:0] frame_index;
    logic [FAULT_W-1:0]     fault_total;

    modport source (output valid, output hit, output frame_index, output fault_total,
                    input ready);
    modport sink   (input valid, input hit, input frame_index, input fault_total,
                    output ready);
endinterface

interface lru_pr_cfg_if import lru_pr_pkg::*; ();
    logic             valid;
    logic             ready;
    logic [CFG_W-1:0] frames_in_use;

    modport source (output valid, output frames_in_use, input ready);
    modport sink   (input valid, input frames_in_use, output ready);
endinterface

`default_nettype wire

### hdl/lru_page_replacement_top.sv
// LRU page replacement, top level. Depends on lru_pr_pkg, lru_pr_channels,
// lru_pr_ctrl and lru_pr_dp.
//
// page_in carries one page number per word; result returns one word per page:
// hit flag, frame that holds the page, and the saturating fault count.
// cfg (always ready) sets the frames in use (0 acts as 1, above FRAMES as
// FRAMES); the user writes it only while idle: the block does not check it.
//
// An accepted page is looked up in the cycle after acceptance (parallel
// compare over all frames plus first-empty and LRU selection, registered),
// and then committed, which updates the frames and loads the result register.
// No page is taken during lookup; the next page is taken in the commit cycle.
// When the receiver stalls, one result waits in the output register while
// the next page is accepted and looked up; commit then holds until the
// result is taken. Reset empties all frames, clears ranks and the fault
// count, and sets the frame count to 8.
`default_nettype none

module lru_page_replacement_top import lru_pr_pkg::*;
#(
    parameter int FRAMES    = FRAMES_DEF,
    parameter int PAGE_BITS = PAGE_BITS_DEF
)
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    lru_pr_page_if.sink     page_in,
    lru_pr_result_if.source result,
    lru_pr_cfg_if.sink      cfg
);

    lru_cmd_t cmd;
    lru_sts_t sts;

    assign cfg.ready = 1'b1;

    lru_pr_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (page_in.valid),
        .in_ready (page_in.ready),
        .sts      (sts),
        .cmd      (cmd)
    );

    lru_pr_dp #(
        .FRAMES    (FRAMES),
        .PAGE_BITS (PAGE_BITS)
    ) u_dp (
        .clk             (clk),
        .rst_n           (rst_n),
        .cmd             (cmd),
        .sts             (sts),
        .page_number     (page_in.page_number),
        .cfg_valid       (cfg.valid),
        .cfg_data        (cfg.frames_in_use),
        .out_ready       (result.ready),
        .out_valid       (result.valid),
        .out_hit         (result.hit),
        .out_frame_index (result.frame_index),
        .out_fault_total (result.fault_total)
    );

endmodule

`default_nettype wire

### hdl/lru_pr_ctrl.sv
// Sequencer for the LRU block: accept, lookup, commit.
// Depends on lru_pr_pkg for the state enum and command/status structs.
`default_nettype none

module lru_pr_ctrl import lru_pr_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic in_valid,
    output logic      in_ready,
    input  lru_sts_t  sts,
    output lru_cmd_t  cmd
);

    lru_state_t state_reg;
    lru_state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = ST_MATCH;
                end
            end
            ST_MATCH:
            begin
                state_next = ST_COMMIT;
            end
            ST_COMMIT:
            begin
                // hold until the result register frees up
                if (sts.out_free)
                begin
                    state_next = in_valid ? ST_MATCH : ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        in_ready   = 1'b0;
        cmd.lookup = 1'b0;
        cmd.commit = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
            end
            ST_MATCH:
            begin
                cmd.lookup = 1'b1;
            end
            ST_COMMIT:
            begin
                // take the next word in the same cycle the current one retires
                in_ready   = sts.out_free;
                cmd.commit = sts.out_free;
            end
            default:
            begin
                in_ready = 1'b0;
            end
        endcase
        cmd.take = in_valid && in_ready;
    end

`ifndef ASSERT_OFF
    a_commit_needs_room: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.commit |-> sts.out_free)
        else $error("commit while result register is full");

    a_no_take_in_lookup: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_MATCH) |-> !cmd.take)
        else $error("word taken during lookup");

    a_lookup_then_commit: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.lookup |=> (state_reg == ST_COMMIT))
        else $error("lookup not followed by commit state");
`endif

endmodule

`default_nettype wire

### hdl/lru_pr_dp.sv
// Datapath for the LRU block: frame table, recency ranks, fault counter,
// configuration register and result register. Depends on lru_pr_pkg.
`default_nettype none

module lru_pr_dp import lru_pr_pkg::*;
#(
    parameter int FRAMES    = FRAMES_DEF,
    parameter int PAGE_BITS = PAGE_BITS_DEF
)
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  lru_cmd_t                    cmd,
    output lru_sts_t                    sts,
    input  wire logic [PAGE_W-1:0]      page_number,
    input  wire logic                   cfg_valid,
    input  wire logic [CFG_W-1:0]       cfg_data,
    input  wire logic                   out_ready,
    output logic                        out_valid,
    output logic                        out_hit,
    output logic [FRAME_IDX_W-1:0]      out_frame_index,
    output logic [FAULT_W-1:0]          out_fault_total
);

    localparam int IDXW = (FRAMES > 1) ? $clog2(FRAMES) : 1;
    localparam logic [IDXW-1:0] RANK_MAX = IDXW'(FRAMES - 1);

    logic [PAGE_BITS-1:0]   page_reg;
    logic [PAGE_BITS-1:0]   frame_page_reg [FRAMES];
    logic [FRAMES-1:0]      valid_reg;
    logic [FRAMES-1:0]      valid_next;
    logic [IDXW-1:0]        rank_reg [FRAMES];
    logic [IDXW-1:0]        rank_next [FRAMES];
    logic [FAULT_W-1:0]     fault_reg;
    logic [FAULT_W-1:0]     fault_next;
    logic [CFG_W-1:0]       cfg_reg;

    // decision registered in the lookup cycle
    logic [IDXW-1:0]        sel_idx_reg;
    logic [IDXW-1:0]        sel_idx_next;
    logic                   hit_sel_reg;
    logic                   fill_sel_reg;

    logic                   out_valid_reg;
    logic                   out_hit_reg;
    logic [FRAME_IDX_W-1:0] out_frame_reg;
    logic [FAULT_W-1:0]     out_fault_reg;

    logic [FRAMES-1:0]      act;
    logic [FRAMES-1:0]      hit_vec;
    logic [FRAMES-1:0]      empty_vec;
    logic [FRAMES-1:0]      max_vec;
    logic [IDXW-1:0]        hit_idx;
    logic [IDXW-1:0]        empty_idx;
    logic [IDXW-1:0]        victim_idx;
    logic [IDXW-1:0]        old_rank;

    assign sts.out_free = !out_valid_reg || out_ready;

    // Lookup: match, first empty frame, and lowest frame with the highest rank
    always_comb
    begin
        for (int k = 0; k < FRAMES; k++)
        begin
            act[k]       = (k == 0) || (32'(cfg_reg) > 32'(k));
            hit_vec[k]   = act[k] && valid_reg[k] && (frame_page_reg[k] == page_reg);
            empty_vec[k] = act[k] && !valid_reg[k];
            max_vec[k]   = act[k];
            for (int j = 0; j < FRAMES; j++)
            begin
                if (act[j] && (rank_reg[j] > rank_reg[k]))
                begin
                    max_vec[k] = 1'b0;
                end
            end
        end
        hit_idx    = '0;
        empty_idx  = '0;
        victim_idx = '0;
        for (int k = FRAMES - 1; k >= 0; k--)
        begin
            if (hit_vec[k])
            begin
                hit_idx = IDXW'(k);
            end
            if (empty_vec[k])
            begin
                empty_idx = IDXW'(k);
            end
            if (max_vec[k])
            begin
                victim_idx = IDXW'(k);
            end
        end
        if (|hit_vec)
        begin
            sel_idx_next = hit_idx;
        end
        else if (|empty_vec)
        begin
            sel_idx_next = empty_idx;
        end
        else
        begin
            sel_idx_next = victim_idx;
        end
    end

    // Commit: age the younger frames, make the selected frame most recent
    always_comb
    begin
        old_rank   = rank_reg[sel_idx_reg];
        valid_next = valid_reg;
        for (int k = 0; k < FRAMES; k++)
        begin
            rank_next[k] = rank_reg[k];
            if (act[k] && valid_reg[k] && (IDXW'(k) != sel_idx_reg)
                && (fill_sel_reg || (rank_reg[k] < old_rank)))
            begin
                rank_next[k] = (rank_reg[k] < RANK_MAX) ? rank_reg[k] + 1'b1 : rank_reg[k];
            end
        end
        rank_next[sel_idx_reg]  = '0;
        valid_next[sel_idx_reg] = 1'b1;
        if (hit_sel_reg || (fault_reg == {FAULT_W{1'b1}}))
        begin
            fault_next = fault_reg;
        end
        else
        begin
            fault_next = fault_reg + 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg     <= '0;
            fault_reg     <= '0;
            cfg_reg       <= CFG_RESET;
            out_valid_reg <= 1'b0;
            for (int k = 0; k < FRAMES; k++)
            begin
                rank_reg[k] <= '0;
            end
        end
        else
        begin
            if (cfg_valid)
            begin
                cfg_reg <= cfg_data;
            end
            if (cmd.commit)
            begin
                valid_reg     <= valid_next;
                fault_reg     <= fault_next;
                rank_reg      <= rank_next;
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Payload registers, no reset
    always_ff @(posedge clk)
    begin
        if (cmd.take)
        begin
            page_reg <= PAGE_BITS'(page_number);
        end
        if (cmd.lookup)
        begin
            sel_idx_reg  <= sel_idx_next;
            hit_sel_reg  <= |hit_vec;
            fill_sel_reg <= !(|hit_vec) && (|empty_vec);
        end
        if (cmd.commit)
        begin
            if (!hit_sel_reg)
            begin
                frame_page_reg[sel_idx_reg] <= page_reg;
            end
            out_hit_reg   <= hit_sel_reg;
            out_frame_reg <= FRAME_IDX_W'(sel_idx_reg);
            out_fault_reg <= fault_next;
        end
    end

    assign out_valid       = out_valid_reg;
    assign out_hit         = out_hit_reg;
    assign out_frame_index = out_frame_reg;
    assign out_fault_total = out_fault_reg;

`ifndef ASSERT_OFF
    a_sel_frame_valid: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.commit |=> valid_reg[sel_idx_reg])
        else $error("committed frame not marked valid");

    a_hit_keeps_faults: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.commit && hit_sel_reg) |=> (fault_reg == $past(fault_reg)))
        else $error("fault count moved on a hit");

    a_result_from_commit: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(cmd.commit))
        else $error("result shown without a commit");
`endif

endmodule

`default_nettype wire

### tb/tb.sv
// Self-checking testbench for lru_page_replacement_top: page words in, results out.
// Depends on lru_pr_pkg and the channel interfaces in lru_pr_channels.
// Every result is checked against an in-bench LRU frame table.
module tb;
    import lru_pr_pkg::*;

    localparam int NFRAMES = FRAMES_DEF;

    typedef struct packed {
        logic                   hit;
        logic [FRAME_IDX_W-1:0] frame_index;
        logic [FAULT_W-1:0]     fault_total;
    } page_result_t;

    logic clk = 1'b0;
    logic rst_n;

    lru_pr_page_if   page_ch ();
    lru_pr_result_if result_ch ();
    lru_pr_cfg_if    cfg_ch ();

    lru_page_replacement_top dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .page_in (page_ch),
        .result  (result_ch),
        .cfg     (cfg_ch)
    );

    // Shadow frame table
    logic [PAGE_W-1:0]  shadow_page  [NFRAMES];
    bit                 shadow_valid [NFRAMES];
    logic [2:0]         shadow_rank  [NFRAMES];
    logic [FAULT_W-1:0] shadow_faults;
    logic [CFG_W-1:0]   shadow_frames;

    page_result_t pending_results[$];

    bit idle_en = 1'b1;
    int fail_count = 0;
    int sent_count = 0;
    int checked_count = 0;
    int hit_count = 0;
    int cfg_writes = 0;
    int stall_left = 0;

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    function automatic int active_frames();
        if (shadow_frames == 0)
            return 1;
        if (shadow_frames > NFRAMES)
            return NFRAMES;
        return int'(shadow_frames);
    endfunction

    // Make frame f most recent; age valid frames younger than it, all if f was empty.
    function automatic void promote(input int n, input int f, input bit was_valid);
        logic [2:0] old_rank;
        old_rank = shadow_rank[f];
        for (int k = 0; k < n; k++)
        begin
            if (k == f || !shadow_valid[k])
                continue;
            if (!was_valid || shadow_rank[k] < old_rank)
                if (shadow_rank[k] < NFRAMES - 1)
                    shadow_rank[k] = 3'(shadow_rank[k] + 1);
        end
        shadow_rank[f] = '0;
    endfunction

    function automatic page_result_t lru_lookup(input logic [PAGE_W-1:0] page);
        page_result_t res;
        int n;
        int f;
        bit hit;
        bit found;
        logic [2:0] oldest;
        n = active_frames();
        f = 0;
        hit = 1'b0;
        found = 1'b0;
        for (int k = 0; k < n; k++)
        begin
            if (shadow_valid[k] && shadow_page[k] == page)
            begin
                f = k;
                hit = 1'b1;
                break;
            end
        end
        if (hit)
            promote(n, f, 1'b1);
        else
        begin
            if (shadow_faults != '1)
                shadow_faults = shadow_faults + 1;
            for (int k = 0; k < n; k++)
            begin
                if (!shadow_valid[k])
                begin
                    f = k;
                    found = 1'b1;
                    break;
                end
            end
            if (found)
            begin
                promote(n, f, 1'b0);
                shadow_valid[f] = 1'b1;
            end
            else
            begin
                // evict the oldest; ties go to the lowest frame
                oldest = shadow_rank[0];
                f = 0;
                for (int k = 1; k < n; k++)
                begin
                    if (shadow_rank[k] > oldest)
                    begin
                        oldest = shadow_rank[k];
                        f = k;
                    end
                end
                promote(n, f, 1'b1);
            end
            shadow_page[f] = page;
        end
        res.hit = hit;
        res.frame_index = FRAME_IDX_W'(f);
        res.fault_total = shadow_faults;
        return res;
    endfunction

    task automatic send_page(input logic [PAGE_W-1:0] page);
        if (idle_en && $urandom_range(0, 5) == 0)
        begin
            page_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 5)) @(posedge clk);
        end
        page_ch.valid <= 1'b1;
        page_ch.page_number <= page;
        do @(posedge clk); while (!page_ch.ready);
        pending_results.push_back(lru_lookup(page));
        sent_count++;
    endtask

    // Hold the sender until every result is back, then let the pipeline settle.
    task automatic wait_drained();
        page_ch.valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_frames(input logic [CFG_W-1:0] value);
        cfg_ch.valid <= 1'b1;
        cfg_ch.frames_in_use <= value;
        do @(posedge clk); while (!cfg_ch.ready);
        cfg_ch.valid <= 1'b0;
        shadow_frames = value;
        cfg_writes++;
        @(posedge clk);
    endtask

    // Result side: random stall bursts and checking of each word
    always @(posedge clk)
    begin
        page_result_t want;
        if (rst_n)
        begin
            if (result_ch.valid && result_ch.ready)
            begin
                checked_count++;
                if (result_ch.hit)
                    hit_count++;
                if (pending_results.size() == 0)
                begin
                    $error("result word with no expectation pending");
                    fail_count++;
                end
                else
                begin
                    want = pending_results.pop_front();
                    if (result_ch.hit !== want.hit)
                    begin
                        $error("hit: expected %0b, got %0b", want.hit, result_ch.hit);
                        fail_count++;
                    end
                    if (result_ch.frame_index !== want.frame_index)
                    begin
                        $error("frame_index: expected %0d, got %0d",
                               want.frame_index, result_ch.frame_index);
                        fail_count++;
                    end
                    if (result_ch.fault_total !== want.fault_total)
                    begin
                        $error("fault_total: expected %0d, got %0d",
                               want.fault_total, result_ch.fault_total);
                        fail_count++;
                    end
                end
            end
            if (stall_left != 0)
            begin
                stall_left <= stall_left - 1;
                result_ch.ready <= 1'b0;
            end
            else if (idle_en && $urandom_range(0, 7) == 0)
            begin
                stall_left <= $urandom_range(0, 4);
                result_ch.ready <= 1'b0;
            end
            else
                result_ch.ready <= 1'b1;
        end
        else
            result_ch.ready <= 1'b0;
    end

    task automatic test_fill_and_evict();
        // Fill all eight frames, hit one, then force replacements
        send_page(16'h0000);
        send_page(16'hFFFF);
        send_page(16'h5555);
        send_page(16'hAAAA);
        send_page(16'h0001);
        send_page(16'h0002);
        send_page(16'h0003);
        send_page(16'h0004);
        send_page(16'hFFFF);
        send_page(16'h0009);
        send_page(16'h0000);
        send_page(16'h5555);
    endtask

    task automatic test_frame_count();
        // zero acts as a single frame
        wait_drained();
        write_frames(CFG_W'(0));
        send_page(16'h0010);
        send_page(16'h0010);
        send_page(16'h0011);
        // one frame
        wait_drained();
        write_frames(CFG_W'(1));
        send_page(16'h0011);
        send_page(16'h0012);
        // shrink, then grow back: frames beyond the count keep their pages and ties appear
        wait_drained();
        write_frames(CFG_W'(3));
        send_page(16'h0020);
        send_page(16'h0021);
        send_page(16'h0022);
        wait_drained();
        write_frames(CFG_W'(15));
        send_page(16'h0003);
        send_page(16'h0030);
        send_page(16'h0031);
        wait_drained();
        write_frames(CFG_W'(8));
        send_page(16'h0032);
        send_page(16'h0033);
    endtask

    task automatic run_random_phase(input logic [CFG_W-1:0] count, input int items);
        logic [PAGE_W-1:0] pool [12];
        int pool_size;
        wait_drained();
        write_frames(count);
        pool_size = $urandom_range(2, 12);
        for (int i = 0; i < 12; i++)
            pool[i] = (i % 2 == 0) ? PAGE_W'($urandom_range(0, 31)) : PAGE_W'($urandom);
        for (int i = 0; i < items; i++)
        begin
            // mostly a small working set so hits and evictions both happen
            if ($urandom_range(0, 9) < 8)
                send_page(pool[$urandom_range(0, pool_size - 1)]);
            else
                send_page(PAGE_W'($urandom));
            if (idle_en && $urandom_range(0, 49) == 0)
                wait_drained();
        end
    endtask

    task automatic test_random();
        logic [CFG_W-1:0] counts [6] = '{4'd1, 4'd8, 4'd15, 4'd0, 4'd2, 4'd9};
        for (int p = 0; p < 6; p++)
            run_random_phase(counts[p], 60);
        for (int p = 0; p < 5; p++)
            run_random_phase(CFG_W'($urandom_range(0, 15)), 60);
    endtask

    task automatic test_streaming();
        idle_en = 1'b0;
        run_random_phase(CFG_W'($urandom_range(3, 8)), 90);
    endtask

    initial
    begin
        rst_n <= 1'b0;
        page_ch.valid <= 1'b0;
        page_ch.page_number <= '0;
        cfg_ch.valid <= 1'b0;
        cfg_ch.frames_in_use <= '0;
        for (int k = 0; k < NFRAMES; k++)
        begin
            shadow_page[k] = '0;
            shadow_valid[k] = 1'b0;
            shadow_rank[k] = '0;
        end
        shadow_faults = '0;
        shadow_frames = CFG_RESET;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_fill_and_evict();
        test_frame_count();
        test_random();
        test_streaming();

        wait_drained();
        repeat (10) @(posedge clk);
        $display("Ran %0d page references (%0d hits) over %0d frame-count settings,",
                 sent_count, hit_count, cfg_writes);
        $display("with stalls on both sides and a final stall-free stretch.");
        if (fail_count == 0 && checked_count == sent_count)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

    initial
    begin
        #400000;
        $display("Simulation FAILED");
        $finish;
    end

endmodule
